// ===== sv/prq_pkg.sv =====
// Package for the priority run queue manager: opcodes, status codes, sizes
// and the structs passed between the front end and the queue engine.
// No dependencies.
package prq_pkg;

  localparam int NUM_PROCS_DEF  = 64;
  localparam int NUM_LEVELS_DEF = 8;

  localparam int OPCODE_W   = 2;
  localparam int PID_W      = 6;
  localparam int PRIO_W     = 3;
  localparam int COUNT_W    = 7;
  localparam int STATUS_W   = 2;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_POP    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [PID_W-1:0]    process_id;
    logic [PRIO_W-1:0]   priority_req;
  } cmd_t;

  typedef struct packed {
    logic [PID_W-1:0]    popped_id;
    logic [COUNT_W-1:0]  queue_count;
    logic [STATUS_W-1:0] status;
  } rsp_t;

endpackage

// ===== sv/prq_if.sv =====
// Valid/ready channel interfaces for commands and responses.
// Depends on prq_pkg.
interface prq_cmd_if
  import prq_pkg::*;
  ();
  logic                in_valid;
  logic                in_ready;
  logic [OPCODE_W-1:0] in_opcode;
  logic [PID_W-1:0]    in_process_id;
  logic [PRIO_W-1:0]   in_priority_req;
  modport source (output in_valid, in_opcode, in_process_id, in_priority_req,
                  input in_ready);
  modport sink (input in_valid, in_opcode, in_process_id, in_priority_req,
                output in_ready);
endinterface

interface prq_rsp_if
  import prq_pkg::*;
  ();
  logic                out_valid;
  logic                out_ready;
  logic [PID_W-1:0]    out_popped_id;
  logic [COUNT_W-1:0]  out_queue_count;
  logic [STATUS_W-1:0] out_status;
  modport source (output out_valid, out_popped_id, out_queue_count, out_status,
                  input out_ready);
  modport sink (input out_valid, out_popped_id, out_queue_count, out_status,
                output out_ready);
endinterface

// ===== sv/prq_cmd_fifo.sv =====
// Front end: accepts commands and buffers them in a two-entry queue.
// Depends on prq_pkg and prq_if.
module prq_cmd_fifo
  import prq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  prq_cmd_if.sink     cmd,
  output logic        deq_valid,
  output cmd_t        deq_cmd,
  input  logic        deq_ready
);

  cmd_t       buf_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] fill_r;

  wire push = cmd.in_valid && cmd.in_ready;
  wire pop  = deq_valid && deq_ready;

  assign cmd.in_ready = (fill_r != 2'd2);
  assign deq_valid    = (fill_r != 2'd0);
  assign deq_cmd      = buf_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wptr_r] <= '{opcode: cmd.in_opcode, process_id: cmd.in_process_id,
                         priority_req: cmd.in_priority_req};
    end
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r == 2'd2 |-> !cmd.in_ready)
    else $error("queue full but ready");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != 2'd3)
    else $error("fill out of range");
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> fill_r != 2'd0)
    else $error("push lost");

endmodule

// ===== sv/prq_engine.sv =====
// Back end: executes queue operations on the link tables through a state sequence.
// Depends on prq_pkg and prq_if.
module prq_engine
  import prq_pkg::*;
#(
  parameter int NUM_PROCS  = NUM_PROCS_DEF,
  parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    cmd_valid,
  input  cmd_t    cmd_in,
  output logic    cmd_ready,
  prq_rsp_if.source rsp
);

  localparam int SW = (NUM_PROCS  > 1) ? $clog2(NUM_PROCS)  : 1;
  localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  localparam int CW = $clog2(NUM_PROCS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;  // read head/slot links
  localparam logic [2:0] S_RD2  = 3'd2;  // check level count; insert writes new slot's own links
  localparam logic [2:0] S_WR   = 3'd3;  // write links
  localparam logic [2:0] S_RSP  = 3'd4;

  // link memories, one write port each, registered reads
  logic [SW-1:0] next_mem [NUM_PROCS];
  logic [SW-1:0] prev_mem [NUM_PROCS];
  logic [LW-1:0] prio_mem [NUM_PROCS];
  logic [NUM_PROCS-1:0]  queued_r;
  logic [SW-1:0]         head_r  [NUM_LEVELS];
  logic [CW-1:0]         count_r [NUM_LEVELS];

  logic [2:0]          state_r;
  logic [OPCODE_W-1:0] op_r;
  logic [SW-1:0]       s_r;      // target slot
  logic [LW-1:0]       lv_r;
  logic [STATUS_W-1:0] st_r;
  logic [SW-1:0]       n_r, p_r; // neighbors (or head/tail on insert)
  logic [PID_W-1:0]    popped_r;
  logic [CW-1:0]       cnt_r;
  logic                busy_link_r; // true when links must be touched

  // memory ports
  logic [SW-1:0] nrd_addr, prd_addr, nrd_q, prd_q;
  logic [SW-1:0] nwr_addr, pwr_addr, nwr_data, pwr_data;
  logic          nwr_en, pwr_en;
  logic [SW-1:0] prio_addr;
  logic [LW-1:0] prio_q;

  always_ff @(posedge clk) begin
    nrd_q  <= next_mem[nrd_addr];
    prd_q  <= prev_mem[prd_addr];
    prio_q <= prio_mem[prio_addr];
    if (nwr_en) next_mem[nwr_addr] <= nwr_data;
    if (pwr_en) prev_mem[pwr_addr] <= pwr_data;
    if (state_r == S_WR && op_r == OP_INSERT && st_r == ST_OK)
      prio_mem[s_r] <= lv_r;
  end

  wire [SW-1:0] in_s  = SW'(cmd_in.process_id % NUM_PROCS);
  wire [LW-1:0] in_lv = LW'(cmd_in.priority_req % NUM_LEVELS);
  wire          take  = cmd_valid && cmd_ready;
  wire          rsp_fire = rsp.out_valid && rsp.out_ready;

  assign cmd_ready       = (state_r == S_IDLE);
  assign rsp.out_valid   = (state_r == S_RSP);
  assign rsp.out_popped_id  = popped_r;
  assign rsp.out_queue_count = COUNT_W'(cnt_r);
  assign rsp.out_status  = st_r;

  // read addressing
  always_comb begin
    prio_addr = in_s;
    nrd_addr  = s_r;
    prd_addr  = s_r;
    if (state_r == S_IDLE) begin
      nrd_addr = in_s;
      prd_addr = (cmd_in.opcode == OP_INSERT) ? head_r[in_lv] : in_s;
      if (cmd_in.opcode == OP_POP) begin
        nrd_addr = head_r[in_lv];
        prd_addr = head_r[in_lv];
      end
    end
  end

  // link writes in S_WR, and the new slot's own links in S_RD2
  always_comb begin
    nwr_en = 1'b0; pwr_en = 1'b0;
    nwr_addr = s_r; pwr_addr = s_r; nwr_data = s_r; pwr_data = s_r;
    if (state_r == S_WR && busy_link_r && st_r == ST_OK && op_r != OP_QUERY) begin
      nwr_en = 1'b1; pwr_en = 1'b1;
      if (op_r == OP_INSERT) begin
        // n_r = head, p_r = tail; tail/head links here, the new slot's own links below
        nwr_addr = p_r; nwr_data = s_r;
        pwr_addr = n_r; pwr_data = s_r;
      end else begin
        nwr_addr = p_r; nwr_data = n_r;
        pwr_addr = n_r; pwr_data = p_r;
      end
    end else if (state_r == S_RD2 && op_r == OP_INSERT && st_r == ST_OK) begin
      // own links of the new slot; a lone entry points at itself
      nwr_en = 1'b1; pwr_en = 1'b1;
      nwr_data = (count_r[lv_r] != '0) ? n_r : s_r;
      pwr_data = (count_r[lv_r] != '0) ? p_r : s_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      queued_r <= '0;
      for (int i = 0; i < NUM_LEVELS; i++) count_r[i] <= '0;
    end else begin
      case (state_r)
        S_IDLE: if (take) begin
          op_r     <= cmd_in.opcode;
          s_r      <= in_s;
          lv_r     <= in_lv;
          st_r     <= ST_OK;
          popped_r <= '0;
          state_r  <= S_RD1;
          case (cmd_in.opcode)
            OP_INSERT: if (queued_r[in_s]) st_r <= ST_DUP;
            OP_POP: begin
              if (count_r[in_lv] == '0) st_r <= ST_EMPTY;
              s_r <= head_r[in_lv];
            end
            OP_REMOVE: if (!queued_r[in_s]) st_r <= ST_ABSENT;
            default: ;
          endcase
        end
        S_RD1: begin
          // remove takes the slot's own level
          if (op_r == OP_REMOVE && st_r == ST_OK) lv_r <= prio_q;
          n_r <= (op_r == OP_INSERT) ? head_r[lv_r] : nrd_q;
          p_r <= prd_q;
          state_r <= S_RD2;
        end
        S_RD2: begin
          if (op_r == OP_INSERT) begin
            busy_link_r <= (count_r[lv_r] != '0);
          end else begin
            busy_link_r <= (count_r[lv_r] > CW'(1));
          end
          state_r <= S_WR;
        end
        S_WR: begin
          state_r <= S_RSP;
          cnt_r   <= count_r[lv_r];
          if (st_r == ST_OK) begin
            case (op_r)
              OP_INSERT: begin
                queued_r[s_r]  <= 1'b1;
                count_r[lv_r]  <= count_r[lv_r] + CW'(1);
                cnt_r          <= count_r[lv_r] + CW'(1);
                if (count_r[lv_r] == '0) head_r[lv_r] <= s_r;
              end
              OP_POP, OP_REMOVE: begin
                queued_r[s_r]  <= 1'b0;
                count_r[lv_r]  <= count_r[lv_r] - CW'(1);
                cnt_r          <= count_r[lv_r] - CW'(1);
                if (busy_link_r && head_r[lv_r] == s_r) head_r[lv_r] <= n_r;
                if (op_r == OP_POP) popped_r <= PID_W'(s_r);
              end
              default: ;
            endcase
          end else if (st_r == ST_EMPTY) begin
            cnt_r <= '0;
          end
        end
        S_RSP: if (rsp_fire) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_rsp_only_in_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.out_valid |-> !cmd_ready)
    else $error("response while accepting");
  a_pop_ok_id: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.out_valid && rsp.out_status == ST_EMPTY |-> rsp.out_queue_count == '0)
    else $error("empty pop with nonzero count");
  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD1 |=> state_r == S_RD2)
    else $error("sequencer skipped a step");

endmodule

// ===== sv/priority_run_queue_manager.sv =====
// Top level of the priority run queue manager.
// Depends on prq_pkg, prq_if, prq_cmd_fifo and prq_engine.
//
// Keeps one circular doubly linked ready queue per priority level over a
// table of process slots. A command (insert, pop, remove, query) gives one
// response. Commands land in a two-entry queue; the engine takes a new
// command only once the previous response has transferred, stepping through
// S_IDLE (accept), S_RD1, S_RD2, S_WR and S_RSP (response); a held-off
// response stalls the engine until it transfers.
module priority_run_queue_manager
  import prq_pkg::*;
#(
  parameter int NUM_PROCS  = NUM_PROCS_DEF,
  parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  prq_cmd_if.sink   in_ch,
  prq_rsp_if.source out_ch
);

  logic q_valid, q_ready;
  cmd_t q_cmd;

  prq_cmd_fifo u_front (
    .clk, .rst_n, .cmd(in_ch),
    .deq_valid(q_valid), .deq_cmd(q_cmd), .deq_ready(q_ready)
  );

  prq_engine #(.NUM_PROCS(NUM_PROCS), .NUM_LEVELS(NUM_LEVELS)) u_engine (
    .clk, .rst_n,
    .cmd_valid(q_valid), .cmd_in(q_cmd), .cmd_ready(q_ready),
    .rsp(out_ch)
  );

endmodule

// ===== tb/prq_tb_if.sv =====
// Testbench-side note: the channel interfaces come from sv/prq_if.sv.
// This file holds the small item struct used by the test's driver and op queue.
// Depends on prq_pkg.
package prq_tb_pkg;
  import prq_pkg::*;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [PID_W-1:0]    pid;
    logic [PRIO_W-1:0]   level;
    logic [3:0]          gap;
  } op_item_t;
endpackage

// ===== tb/priority_run_queue_manager_test.sv =====
// Self-checking test for priority_run_queue_manager: directed and random
// queue operations, predicted by a behavioral copy of the ready queues.
// Depends on prq_pkg, prq_if, prq_tb_pkg and priority_run_queue_manager.
module priority_run_queue_manager_test;
  import prq_pkg::*;
  import prq_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  prq_cmd_if in_ch();
  prq_rsp_if out_ch();

  priority_run_queue_manager uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  // behavioral queue state
  logic [PID_W-1:0]   nxt [64];
  logic [PID_W-1:0]   prv [64];
  logic [PRIO_W-1:0]  lvl_of [64];
  logic               queued [64];
  logic [PID_W-1:0]   head [8];
  logic [COUNT_W-1:0] cnt [8];

  op_item_t pending_ops[$];
  rsp_t     expected_rsps[$];
  int       errors = 0;
  int       cycles = 0;
  int       hold_off = 0;
  bit       drain_wait = 0;
  int       in_gap = 0;
  int       out_gap = 0;

  function automatic void unlink(input logic [PID_W-1:0] s, input logic [PRIO_W-1:0] lv);
    if (cnt[lv] <= 1) begin
      cnt[lv] = 0;
    end else begin
      nxt[prv[s]] = nxt[s];
      prv[nxt[s]] = prv[s];
      if (head[lv] == s) head[lv] = nxt[s];
      cnt[lv] = cnt[lv] - 1;
    end
    queued[s] = 1'b0;
  endfunction

  function automatic rsp_t apply_op(input op_item_t it);
    rsp_t r;
    logic [PRIO_W-1:0] lv;
    logic [PID_W-1:0] s, h, t;
    r = '0;
    s = it.pid;
    lv = it.level;
    r.status = ST_OK;
    case (it.opcode)
      OP_INSERT: begin
        if (queued[s]) begin
          r.status = ST_DUP;
        end else begin
          lvl_of[s] = lv;
          if (cnt[lv] == 0) begin
            nxt[s] = s; prv[s] = s; head[lv] = s;
          end else begin
            h = head[lv]; t = prv[h];
            nxt[s] = h; prv[s] = t; nxt[t] = s; prv[h] = s;
          end
          cnt[lv] = cnt[lv] + 1;
          queued[s] = 1'b1;
        end
      end
      OP_POP: begin
        if (cnt[lv] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          h = head[lv];
          unlink(h, lv);
          r.popped_id = h;
        end
      end
      OP_REMOVE: begin
        if (!queued[s]) begin
          r.status = ST_ABSENT;
        end else begin
          lv = lvl_of[s];
          unlink(s, lv);
        end
      end
      default: ;
    endcase
    r.queue_count = cnt[lv];
    return r;
  endfunction

  function automatic void add_op(input logic [1:0] op, input int pid, input int lv,
                                 input int gap);
    op_item_t it;
    it.opcode = op;
    it.pid = pid;
    it.level = lv;
    it.gap = gap;
    pending_ops.push_back(it);
  endfunction

  // driver
  always @(posedge clk) begin
    op_item_t it;
    if (!rst_n) begin
      in_ch.in_valid <= 1'b0;
    end else if (in_ch.in_valid && !in_ch.in_ready) begin
      // hold the offered item
    end else begin
      if (in_ch.in_valid) begin
        expected_rsps.push_back(apply_op('{in_ch.in_opcode, in_ch.in_process_id,
                                           in_ch.in_priority_req, 4'd0}));
      end
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.in_valid <= 1'b0;
      end else if (pending_ops.size() > 0 && !(drain_wait && expected_rsps.size() > 0
                                                  || drain_wait && in_ch.in_valid)) begin
        it = pending_ops.pop_front();
        in_ch.in_valid <= 1'b1;
        in_ch.in_opcode <= it.opcode;
        in_ch.in_process_id <= it.pid;
        in_ch.in_priority_req <= it.level;
        in_gap <= it.gap;
      end else begin
        in_ch.in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rsp_t exp_r;
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_ch.out_ready <= 1'b0;
    end else begin
      if (out_ch.out_valid && out_ch.out_ready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected transfer popped=%0d count=%0d status=%0d", $time,
                   out_ch.out_popped_id, out_ch.out_queue_count, out_ch.out_status);
          errors++;
        end else begin
          exp_r = expected_rsps.pop_front();
          if (exp_r.popped_id !== out_ch.out_popped_id) begin
            $display("%0t: popped_id expected %0d actual %0d", $time, exp_r.popped_id,
                     out_ch.out_popped_id);
            errors++;
          end
          if (exp_r.queue_count !== out_ch.out_queue_count) begin
            $display("%0t: queue_count expected %0d actual %0d", $time,
                     exp_r.queue_count, out_ch.out_queue_count);
            errors++;
          end
          if (exp_r.status !== out_ch.out_status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                     out_ch.out_status);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ch.out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.out_ready <= 1'b0;
      end else begin
        out_ch.out_ready <= 1'b1;
        if (out_ch.out_valid && out_ch.out_ready)
          out_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
      end
    end
  end

  initial begin
    int k, op, lv, pid, gap;
    in_ch.in_valid = 1'b0;
    in_ch.in_opcode = OP_QUERY;
    in_ch.in_process_id = '0;
    in_ch.in_priority_req = '0;
    out_ch.out_ready = 1'b0;
    foreach (queued[i]) queued[i] = 1'b0;
    foreach (cnt[i]) cnt[i] = '0;

    // directed: empty pop, absent remove, extremes, dup, head/middle removal
    add_op(OP_POP, 0, 7, 0);
    add_op(OP_REMOVE, 63, 5, 0);
    add_op(OP_QUERY, 63, 0, 0);
    add_op(OP_INSERT, 0, 0, 0);
    add_op(OP_INSERT, 63, 7, 0);
    add_op(OP_INSERT, 63, 3, 0);
    add_op(OP_INSERT, 21, 7, 0);
    add_op(OP_INSERT, 42, 7, 0);
    add_op(OP_QUERY, 0, 7, 0);
    add_op(OP_REMOVE, 21, 0, 0);
    add_op(OP_REMOVE, 63, 0, 0);
    add_op(OP_INSERT, 5, 7, 0);
    add_op(OP_POP, 17, 7, 0);
    add_op(OP_POP, 0, 7, 0);
    add_op(OP_POP, 0, 7, 0);
    add_op(OP_REMOVE, 0, 2, 0);
    add_op(OP_POP, 0, 0, 0);
    add_op(OP_QUERY, 0, 0, 0);
    add_op(OP_INSERT, 42, 0, 0);
    add_op(OP_REMOVE, 42, 6, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // random: op mix; k%300 < 150 uses levels 0-1 so queues grow deep
    for (k = 0; k < 1500; k++) begin
      op = $urandom_range(0, 9);
      if (op < 4) op = OP_INSERT;
      else if (op < 6) op = OP_POP;
      else if (op < 8) op = OP_REMOVE;
      else op = OP_QUERY;
      lv = (k % 300 < 150) ? $urandom_range(0, 1) : $urandom_range(0, 7);
      pid = $urandom_range(0, 63);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
      if (k >= 600 && k < 700) gap = 0;
      add_op(op[1:0], pid, lv, gap);
      if (k == 600) hold_off = 200;
    end

    // pause the sender until drained once, mid-run
    wait (pending_ops.size() < 800);
    drain_wait = 1;
    wait (expected_rsps.size() == 0 && !in_ch.in_valid);
    @(posedge clk);
    drain_wait = 0;

    wait (pending_ops.size() == 0);
    @(posedge clk);
    wait (!in_ch.in_valid);
    wait (expected_rsps.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > 200000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end
endmodule

// ===== filelist.f =====
sv/prq_pkg.sv
sv/prq_if.sv
sv/prq_cmd_fifo.sv
sv/prq_engine.sv
sv/priority_run_queue_manager.sv
tb/prq_tb_if.sv
tb/priority_run_queue_manager_test.sv
